// ===== src/sdzm_pkg.sv =====
`default_nettype none

package sdzm_pkg;

	// Sample width; a sample is signed Q1.(SAMPLE_BITS-1).
	localparam int SAMPLE_BITS = 16;
	localparam int INNER_W     = SAMPLE_BITS - 1;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int ROOT_STAGES = SAMPLE_BITS;
	localparam int DIV_STAGES  = SAMPLE_BITS;
	localparam int ROOT_REM_W  = SAMPLE_BITS + 1;
	localparam int CFG_INDEX_W = 2;

	localparam logic [SAMPLE_BITS-1:0] OUTER_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] OUT_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INNER = 2'd0,
		REG_OUTER = 2'd1
	} reg_index_t;

	// Per-sample values carried down the pipeline after the dead zone.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] dr;
		logic [SAMPLE_BITS-1:0] du;
		logic                   neg_r;
		logic                   neg_u;
		logic                   zero;
		logic [SAMPLE_BITS-1:0] den;
	} item_t;

	// Output of the front stages: item, sum of squares, and the outside flag.
	typedef struct packed {
		item_t           item;
		logic [SQ_W-1:0] sum_sq;
		logic            outside;
	} front_t;

	// Output of the root pipeline.
	typedef struct packed {
		item_t                  item;
		logic                   outside;
		logic [SAMPLE_BITS-1:0] root;
	} root_t;

	// Input of the divider pipeline.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] dr;
		logic [SAMPLE_BITS-1:0] du;
		logic [SAMPLE_BITS-1:0] divisor;
		logic                   neg_r;
		logic                   neg_u;
		logic                   zero;
	} div_in_t;

	// Output of the divider pipeline.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] q_r;
		logic [SAMPLE_BITS-1:0] q_u;
		logic                   neg_r;
		logic                   neg_u;
		logic                   zero;
	} div_out_t;

endpackage

`default_nettype wire

// ===== src/sdzm_front.sv =====
`default_nettype none

module sdzm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sdzm_pkg::SAMPLE_BITS-1:0] stick_right,
	input  logic signed [sdzm_pkg::SAMPLE_BITS-1:0] stick_up,
	input  logic [sdzm_pkg::INNER_W-1:0]        inner,
	input  logic [sdzm_pkg::SAMPLE_BITS-1:0]    outer,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sdzm_pkg::front_t                    out_data
);
	import sdzm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [SAMPLE_BITS-1:0] mag_r_s1, mag_u_s1, den_s1;
	logic                   neg_r_s1, neg_u_s1, zero_s1;
	logic [INNER_W-1:0]     inner_s1;
	item_t                  item_s2, item_s3;
	logic [SQ_W-1:0]        sq_r_s3, sq_u_s3, den_sq_s3;
	front_t                 front_s4;

	logic [SAMPLE_BITS-1:0] raw_r, raw_u, mag_r, mag_u;
	logic [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS-1:0] inner_ext;
	logic [SQ_W-1:0]        sum_sq;

	// A stage loads when it is empty or the stage after it moves on.
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: sign and magnitude of each axis, span between the zones.
	assign raw_r     = stick_right;
	assign raw_u     = stick_up;
	assign mag_r     = raw_r[SAMPLE_BITS-1] ? (~raw_r + 1'b1) : raw_r;
	assign mag_u     = raw_u[SAMPLE_BITS-1] ? (~raw_u + 1'b1) : raw_u;
	assign inner_ext = {1'b0, inner};
	assign diff      = {1'b0, outer} - {1'b0, inner_ext};

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mag_r_s1 <= mag_r;
			mag_u_s1 <= mag_u;
			neg_r_s1 <= raw_r[SAMPLE_BITS-1];
			neg_u_s1 <= raw_u[SAMPLE_BITS-1];
			zero_s1  <= (outer <= inner_ext);
			den_s1   <= diff[SAMPLE_BITS-1:0];
			inner_s1 <= inner;
		end
	end

	// Stage 2: remove the axial dead zone, never going below zero.
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			item_s2.dr    <= (mag_r_s1 > {1'b0, inner_s1}) ?
				(mag_r_s1 - {1'b0, inner_s1}) : '0;
			item_s2.du    <= (mag_u_s1 > {1'b0, inner_s1}) ?
				(mag_u_s1 - {1'b0, inner_s1}) : '0;
			item_s2.neg_r <= neg_r_s1;
			item_s2.neg_u <= neg_u_s1;
			item_s2.zero  <= zero_s1;
			item_s2.den   <= den_s1;
		end
	end

	// Stage 3: squares of both axes and of the span.
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			item_s3   <= item_s2;
			sq_r_s3   <= SQ_W'(item_s2.dr) * SQ_W'(item_s2.dr);
			sq_u_s3   <= SQ_W'(item_s2.du) * SQ_W'(item_s2.du);
			den_sq_s3 <= SQ_W'(item_s2.den) * SQ_W'(item_s2.den);
		end
	end

	// Stage 4: squared length and whether it lies outside the circle.
	assign sum_sq = sq_r_s3 + sq_u_s3;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			front_s4.item    <= item_s3;
			front_s4.sum_sq  <= sum_sq;
			front_s4.outside <= (sum_sq > den_sq_s3);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = front_s4;

endmodule

`default_nettype wire

// ===== src/sdzm_sqrt.sv =====
`default_nettype none

module sdzm_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sdzm_pkg::front_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sdzm_pkg::root_t  out_data
);
	import sdzm_pkg::*;

	logic                   v_q    [ROOT_STAGES];
	front_t                 data_q [ROOT_STAGES];
	logic [ROOT_REM_W-1:0]  rem_q  [ROOT_STAGES];
	logic [SAMPLE_BITS-1:0] root_q [ROOT_STAGES];

	wire logic [ROOT_STAGES-1:0] en;
	wire logic                   v_in    [ROOT_STAGES];
	wire front_t                 d_in    [ROOT_STAGES];
	wire logic [ROOT_REM_W-1:0]  rem_in  [ROOT_STAGES];
	wire logic [SAMPLE_BITS-1:0] root_in [ROOT_STAGES];

	// One root bit per stage, taking two radicand bits from the top down.
	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
		logic [ROOT_REM_W+1:0] tmp, trial, diff;
		logic                  fits;

		if (k == 0) begin : g_head
			assign v_in[k]    = in_valid;
			assign d_in[k]    = in_data;
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
		end else begin : g_body
			assign v_in[k]    = v_q[k-1];
			assign d_in[k]    = data_q[k-1];
			assign rem_in[k]  = rem_q[k-1];
			assign root_in[k] = root_q[k-1];
		end

		if (k == ROOT_STAGES - 1) begin : g_tail_en
			assign en[k] = !v_q[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !v_q[k] || en[k+1];
		end

		// Trial subtraction of 4*root + 1 from the shifted remainder.
		always_comb begin
			tmp   = {rem_in[k], d_in[k].sum_sq[SQ_W-1-2*k -: 2]};
			trial = {1'b0, root_in[k], 2'b01};
			diff  = tmp - trial;
			fits  = (tmp >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= v_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_in[k]) begin
				data_q[k] <= d_in[k];
				rem_q[k]  <= fits ? diff[ROOT_REM_W-1:0] : tmp[ROOT_REM_W-1:0];
				root_q[k] <= {root_in[k][SAMPLE_BITS-2:0], fits};
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[ROOT_STAGES-1];
	assign out_data  = '{item:    data_q[ROOT_STAGES-1].item,
	                     outside: data_q[ROOT_STAGES-1].outside,
	                     root:    root_q[ROOT_STAGES-1]};

endmodule

`default_nettype wire

// ===== src/sdzm_div.sv =====
`default_nettype none

module sdzm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sdzm_pkg::div_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sdzm_pkg::div_out_t out_data
);
	import sdzm_pkg::*;

	logic                   v_q     [DIV_STAGES];
	div_in_t                data_q  [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] rem_r_q [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] rem_u_q [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] q_r_q   [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] q_u_q   [DIV_STAGES];

	wire logic [DIV_STAGES-1:0]  en;
	wire logic                   v_in     [DIV_STAGES];
	wire div_in_t                d_in     [DIV_STAGES];
	wire logic [SAMPLE_BITS-1:0] rem_r_in [DIV_STAGES];
	wire logic [SAMPLE_BITS-1:0] rem_u_in [DIV_STAGES];
	wire logic [SAMPLE_BITS-1:0] q_r_in   [DIV_STAGES];
	wire logic [SAMPLE_BITS-1:0] q_u_in   [DIV_STAGES];
	wire logic                   bit_r    [DIV_STAGES];
	wire logic                   bit_u    [DIV_STAGES];

	// Restoring division of d * FULL_SCALE, one quotient bit per stage.
	// The dividend's low bits are all zero, so only the first stage brings
	// in a bit of the magnitude itself.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [SAMPLE_BITS:0] cand_r, cand_u, dv, diff_r, diff_u;
		logic                 fit_r, fit_u;

		if (k == 0) begin : g_head
			assign v_in[k]     = in_valid;
			assign d_in[k]     = in_data;
			assign rem_r_in[k] = {1'b0, in_data.dr[SAMPLE_BITS-1:1]};
			assign rem_u_in[k] = {1'b0, in_data.du[SAMPLE_BITS-1:1]};
			assign bit_r[k]    = in_data.dr[0];
			assign bit_u[k]    = in_data.du[0];
			assign q_r_in[k]   = '0;
			assign q_u_in[k]   = '0;
		end else begin : g_body
			assign v_in[k]     = v_q[k-1];
			assign d_in[k]     = data_q[k-1];
			assign rem_r_in[k] = rem_r_q[k-1];
			assign rem_u_in[k] = rem_u_q[k-1];
			assign bit_r[k]    = 1'b0;
			assign bit_u[k]    = 1'b0;
			assign q_r_in[k]   = q_r_q[k-1];
			assign q_u_in[k]   = q_u_q[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_tail_en
			assign en[k] = !v_q[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !v_q[k] || en[k+1];
		end

		// Shift in the next dividend bit and try to subtract the divisor.
		always_comb begin
			dv     = {1'b0, d_in[k].divisor};
			cand_r = {rem_r_in[k], bit_r[k]};
			cand_u = {rem_u_in[k], bit_u[k]};
			diff_r = cand_r - dv;
			diff_u = cand_u - dv;
			fit_r  = (cand_r >= dv);
			fit_u  = (cand_u >= dv);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= v_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_in[k]) begin
				data_q[k]  <= d_in[k];
				rem_r_q[k] <= fit_r ? diff_r[SAMPLE_BITS-1:0] : cand_r[SAMPLE_BITS-1:0];
				rem_u_q[k] <= fit_u ? diff_u[SAMPLE_BITS-1:0] : cand_u[SAMPLE_BITS-1:0];
				q_r_q[k]   <= {q_r_in[k][SAMPLE_BITS-2:0], fit_r};
				q_u_q[k]   <= {q_u_in[k][SAMPLE_BITS-2:0], fit_u};
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[DIV_STAGES-1];
	assign out_data  = '{q_r:   q_r_q[DIV_STAGES-1],
	                     q_u:   q_u_q[DIV_STAGES-1],
	                     neg_r: data_q[DIV_STAGES-1].neg_r,
	                     neg_u: data_q[DIV_STAGES-1].neg_u,
	                     zero:  data_q[DIV_STAGES-1].zero};

endmodule

`default_nettype wire

// ===== src/stick_dead_zone_mapper_unit.sv =====
// An accepted input beat passes through 4 front stages, 16 square-root stages at one
// root bit each, 16 divider stages at one quotient bit each and 1 output register.
// Throughput: one beat per cycle while out_ready is high; a stalled output only
// holds the stages that are full, so bubbles ahead of it still fill.
// Reset (arst_n low) empties the pipeline and sets inner_half_width to 0 and
// outer_radius to full scale; a configuration write takes effect on the next beat.
`default_nettype none

module stick_dead_zone_mapper_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sdzm_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [sdzm_pkg::SAMPLE_BITS-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [sdzm_pkg::SAMPLE_BITS-1:0] stick_right,
	input  logic signed [sdzm_pkg::SAMPLE_BITS-1:0] stick_up,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [sdzm_pkg::SAMPLE_BITS-1:0] mapped_right,
	output logic signed [sdzm_pkg::SAMPLE_BITS-1:0] mapped_up
);
	import sdzm_pkg::*;

	logic [INNER_W-1:0]     inner_q;
	logic [SAMPLE_BITS-1:0] outer_q;

	logic     front_valid, front_ready;
	front_t   front_data;
	logic     root_valid, root_ready;
	root_t    root_data;
	div_in_t  div_in;
	logic     div_valid, div_ready;
	div_out_t div_data;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] mapped_right_q, mapped_up_q;
	logic [SAMPLE_BITS-1:0] sat_r, sat_u;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			outer_q <= OUTER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INNER: inner_q <= cfg_data[INNER_W-1:0];
				REG_OUTER: outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sdzm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.stick_right(stick_right),
		.stick_up   (stick_up),
		.inner      (inner_q),
		.outer      (outer_q),
		.out_valid  (front_valid),
		.out_ready  (front_ready),
		.out_data   (front_data)
	);

	sdzm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_data  (front_data),
		.out_valid(root_valid),
		.out_ready(root_ready),
		.out_data (root_data)
	);

	// Inside the circle the span is the divisor, outside the vector length.
	assign div_in = '{dr:      root_data.item.dr,
	                  du:      root_data.item.du,
	                  divisor: root_data.outside ? root_data.root : root_data.item.den,
	                  neg_r:   root_data.item.neg_r,
	                  neg_u:   root_data.item.neg_u,
	                  zero:    root_data.item.zero};

	sdzm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (root_valid),
		.in_ready (root_ready),
		.in_data  (div_in),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.out_data (div_data)
	);

	// Output register: saturate, restore the sign, force zero when disabled.
	assign div_ready = !out_valid_q || out_ready;
	assign sat_r     = div_data.q_r[SAMPLE_BITS-1] ? OUT_MAX : div_data.q_r;
	assign sat_u     = div_data.q_u[SAMPLE_BITS-1] ? OUT_MAX : div_data.q_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ready) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready && div_valid) begin
			if (div_data.zero) begin
				mapped_right_q <= '0;
				mapped_up_q    <= '0;
			end else begin
				mapped_right_q <= div_data.neg_r ? (~sat_r + 1'b1) : sat_r;
				mapped_up_q    <= div_data.neg_u ? (~sat_u + 1'b1) : sat_u;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_right = mapped_right_q;
	assign mapped_up    = mapped_up_q;

endmodule

`default_nettype wire

// ===== src/sdzm_checker.sv =====
`default_nettype none

module sdzm_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [sdzm_pkg::SAMPLE_BITS-1:0] mapped_right,
	input logic signed [sdzm_pkg::SAMPLE_BITS-1:0] mapped_up
);
	import sdzm_pkg::*;

	// Saturation and sign restore never produce the most negative code.
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mapped_right != SAMPLE_MIN) && (mapped_up != SAMPLE_MIN))
		else $error("result beat carries the most negative code");

	// A result beat that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped_right) && $stable(mapped_up))
		else $error("stalled result beat changed or dropped");

	// With the output empty every stage can move, so input is taken.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while the output stage is empty");

	// Reset empties the output stage.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result beat shown during reset");

endmodule

bind stick_dead_zone_mapper_unit sdzm_checker u_sdzm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mapped_right(mapped_right),
	.mapped_up   (mapped_up)
);

`default_nettype wire
